/* hdl/lfo_pkg.sv */
`timescale 1ns / 1ps

package lfo_pkg;

  localparam int PHASE_BITS_DEFAULT = 32;
  localparam int SINE_DEPTH_DEFAULT = 256;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int INC_W       = 32;
  localparam int SAMPLE_W    = 16;
  localparam int PHASE_TOP_W = 16;
  localparam int SINE_W      = 15;

  // Pi in Q30, used to build the quarter-wave table.
  localparam logic [63:0] PiQ30 = 64'd3373259426;
  localparam logic [63:0] Q30One = 64'd1 << 30;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHASE_INCREMENT = 2'd0,
    REG_WAVE_SHAPE      = 2'd1,
    REG_KEY_SYNC_ENABLE = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    SHAPE_SAW      = 2'd0,
    SHAPE_TRIANGLE = 2'd1,
    SHAPE_SQUARE   = 2'd2,
    SHAPE_SINE     = 2'd3
  } wave_shape_t;

  // One quarter-wave table entry from its angle x (Q30 radians): a nested
  // Taylor series with truncating products, rounded to Q0.15.
  function automatic logic [SINE_W-1:0] sine_entry(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x2 = (x * x) >> 30;
    t  = Q30One;
    t  = Q30One - (((x2 * t) >> 30) / 156);
    t  = Q30One - (((x2 * t) >> 30) / 110);
    t  = Q30One - (((x2 * t) >> 30) / 72);
    t  = Q30One - (((x2 * t) >> 30) / 42);
    t  = Q30One - (((x2 * t) >> 30) / 20);
    t  = Q30One - (((x2 * t) >> 30) / 6);
    s  = (x * t) >> 30;
    s  = (s * 64'd32767 + (Q30One >> 1)) >> 30;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[SINE_W-1:0];
  endfunction

endpackage

/* hdl/lfo_tick_if.sv */
`timescale 1ns / 1ps

interface lfo_tick_if;
  logic valid;
  logic ready;
  logic retrigger;

  modport source (output valid, output retrigger, input ready);
  modport sink (input valid, input retrigger, output ready);
endinterface

/* hdl/lfo_sample_if.sv */
`timescale 1ns / 1ps

interface lfo_sample_if;
  logic valid;
  logic ready;
  logic signed [lfo_pkg::SAMPLE_W-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

/* hdl/lfo_cfg_if.sv */
`timescale 1ns / 1ps

interface lfo_cfg_if;
  logic valid;
  logic ready;
  logic [lfo_pkg::CFG_INDEX_W-1:0] index;
  logic [lfo_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/lfo_shaper.sv */
`timescale 1ns / 1ps

module lfo_shaper #(
  parameter int SINE_TABLE_DEPTH = lfo_pkg::SINE_DEPTH_DEFAULT
) (
  input  logic [lfo_pkg::PHASE_TOP_W-1:0]   phase_top,
  input  lfo_pkg::wave_shape_t              shape,
  output logic signed [lfo_pkg::SAMPLE_W-1:0] value
);

  localparam int IdxW = $clog2(SINE_TABLE_DEPTH);
  localparam logic [IdxW:0] Depth = (IdxW + 1)'(SINE_TABLE_DEPTH);

  logic [lfo_pkg::SINE_W-1:0] rom [SINE_TABLE_DEPTH];

  // Quarter-wave table, fixed at elaboration.
  for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
    localparam logic [63:0] Angle = (lfo_pkg::PiQ30 * 64'(i)) / (2 * SINE_TABLE_DEPTH);
    assign rom[i] = lfo_pkg::sine_entry(Angle);
  end

  logic signed [16:0] centered;
  logic [15:0] offset_mag;
  logic signed [17:0] tri_wide;
  logic [1:0] quadrant;
  logic [13:0] frac;
  logic [IdxW+14:0] prod;
  logic [IdxW:0] k;
  logic [IdxW:0] j;
  logic [lfo_pkg::SINE_W-1:0] sine_mag;
  logic signed [lfo_pkg::SAMPLE_W-1:0] sine_val;

  always_comb begin
    centered = $signed({1'b0, phase_top}) - 17'sd32768;
    offset_mag = centered[16] ? 16'(-centered) : centered[15:0];
    tri_wide = 18'sd32768 - $signed({1'b0, offset_mag, 1'b0});

    quadrant = phase_top[15:14];
    frac = phase_top[13:0];
    prod = (IdxW + 15)'(frac) * (IdxW + 15)'(Depth);
    k = prod[IdxW+14:14];
    j = quadrant[0] ? (Depth - k) : k;
    // The mirrored read at the quadrant edge lands one past the table: full scale.
    if (j >= Depth) begin
      sine_mag = 15'h7fff;
    end else begin
      sine_mag = rom[j[IdxW-1:0]];
    end
    sine_val = quadrant[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

    case (shape)
      lfo_pkg::SHAPE_SAW: begin
        value = centered[15:0];
      end
      lfo_pkg::SHAPE_TRIANGLE: begin
        value = (tri_wide > 18'sd32767) ? 16'sd32767 : tri_wide[15:0];
      end
      lfo_pkg::SHAPE_SQUARE: begin
        value = phase_top[15] ? -16'sd32768 : 16'sd32767;
      end
      lfo_pkg::SHAPE_SINE: begin
        value = sine_val;
      end
      default: begin
        value = '0;
      end
    endcase
  end

endmodule

/* hdl/lfo_waveform_generator.sv */
`timescale 1ns / 1ps

// Low-frequency oscillator: every tick transfer produces exactly one Q1.15
// sample transfer of the selected waveform (saw, triangle, square or
// quarter-wave sine) at the current phase, after which the phase advances by
// phase_increment. With key_sync_enable set, a tick carrying retrigger starts
// from phase zero. The block takes one tick per clock cycle unless sample
// back-pressure stalls it; a sample passes the phase register stage, then the
// waveform result register. Registers must be written by the user through cfg
// only while no tick is in flight; the block itself does not enforce this.
module lfo_waveform_generator #(
  parameter int PHASE_BITS       = lfo_pkg::PHASE_BITS_DEFAULT,
  parameter int SINE_TABLE_DEPTH = lfo_pkg::SINE_DEPTH_DEFAULT
) (
  input logic clk,
  input logic rst,
  lfo_tick_if.sink     tick,
  lfo_sample_if.source sample,
  lfo_cfg_if.sink      cfg
);

  logic [lfo_pkg::INC_W-1:0] phase_increment;
  lfo_pkg::wave_shape_t wave_shape;
  logic key_sync_enable;

  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [PHASE_BITS-1:0] inc;

  logic stage_valid;
  logic [lfo_pkg::PHASE_TOP_W-1:0] stage_phase;
  logic stage_load;
  logic tick_fire;

  logic out_valid;
  logic signed [lfo_pkg::SAMPLE_W-1:0] out_value;
  logic signed [lfo_pkg::SAMPLE_W-1:0] shaped;

  // Scale the 32-bit increment to the accumulator width.
  if (PHASE_BITS >= lfo_pkg::INC_W) begin : g_inc_up
    assign inc = PHASE_BITS'(phase_increment) << (PHASE_BITS - lfo_pkg::INC_W);
  end else begin : g_inc_dn
    assign inc = PHASE_BITS'(phase_increment >> (lfo_pkg::INC_W - PHASE_BITS));
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= '0;
      wave_shape <= lfo_pkg::SHAPE_SAW;
      key_sync_enable <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        lfo_pkg::REG_PHASE_INCREMENT: begin
          phase_increment <= cfg.data;
        end
        lfo_pkg::REG_WAVE_SHAPE: begin
          wave_shape <= lfo_pkg::wave_shape_t'(cfg.data[1:0]);
        end
        lfo_pkg::REG_KEY_SYNC_ENABLE: begin
          key_sync_enable <= cfg.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // The result register takes a new sample whenever it is empty or being drained.
  assign stage_load = stage_valid && (!out_valid || sample.ready);
  assign tick.ready = !stage_valid || stage_load;
  assign tick_fire = tick.valid && tick.ready;

  assign phase_cur = (key_sync_enable && tick.retrigger) ? '0 : phase_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      stage_valid <= 1'b0;
    end else begin
      if (tick_fire) begin
        phase_acc <= phase_cur + inc;
        stage_valid <= 1'b1;
      end else if (stage_load) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      stage_phase <= phase_cur[PHASE_BITS-1 -: lfo_pkg::PHASE_TOP_W];
    end
  end

  lfo_shaper #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_shaper (
    .phase_top(stage_phase),
    .shape(wave_shape),
    .value(shaped)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_load) begin
      out_valid <= 1'b1;
    end else if (sample.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_load) begin
      out_value <= shaped;
    end
  end

  assign sample.valid = out_valid;
  assign sample.sample_value = out_value;

endmodule
